FILE: hw/rtl/dmg_pkg.sv
// ----------------------------------------------------------------------------
// dmg_pkg: shared types and constants of the maze carver
// Item codes, result codes, wall directions, cell entry layout and the
// sequencer state type.
// ----------------------------------------------------------------------------
package dmg_pkg;

	localparam int CELL_W = 10;
	localparam int KIND_W = 2;
	localparam int PICK_W = 8;
	localparam int ACT_W  = 3;
	localparam int WALL_W = 4;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STEP  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_CARVED    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_BACKTRACK = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FINISHED  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_START_OK  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_START_IGN = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd5;

	localparam logic [1:0] DIR_TOP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT  = 2'd1;
	localparam logic [1:0] DIR_BOTTOM = 2'd2;
	localparam logic [1:0] DIR_LEFT   = 2'd3;

	localparam logic [2:0] NB_CNT = 3'd4;
	localparam logic [WALL_W-1:0] WALL_ALL = 4'hF;

	typedef struct packed {
		logic              vis;
		logic [WALL_W-1:0] walls;
	} cell_ent_t;

	localparam cell_ent_t CELL_RESET = '{vis: 1'b0, walls: WALL_ALL};

	typedef struct packed {
		logic       carve;
		logic [1:0] dir;
	} pick_res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STACK,
		ST_FETCH,
		ST_PICK,
		ST_WR_TOP,
		ST_WR_NB,
		ST_DIV,
		ST_REPORT,
		ST_DONE
	} state_t;

	function automatic logic [WALL_W-1:0] wall_mask(input logic [1:0] d);
		return 4'b0001 << d;
	endfunction

	function automatic logic [1:0] mod3_u8(input logic [PICK_W-1:0] v);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

FILE: hw/rtl/dmg_ram.sv
// ----------------------------------------------------------------------------
// dmg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while idle.
// ----------------------------------------------------------------------------
module dmg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/dmg_pick.sv
// ----------------------------------------------------------------------------
// dmg_pick: neighbour choice
// Counts open neighbours, reduces the random value by that count and
// selects the matching direction in top, right, bottom, left order.
// ----------------------------------------------------------------------------
module dmg_pick (
	input  logic [3:0]                  cand,
	input  logic [dmg_pkg::PICK_W-1:0]  random_pick,
	output dmg_pkg::pick_res_t          res
);

	logic [2:0] n;
	logic [2:0] pos;
	logic [2:0] seen;
	logic [1:0] dir;

	assign n = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

	always_comb begin
		unique case (n)
			3'd2:    pos = {2'b00, random_pick[0]};
			3'd3:    pos = {1'b0, dmg_pkg::mod3_u8(random_pick)};
			3'd4:    pos = {1'b0, random_pick[1:0]};
			default: pos = 3'd0;
		endcase
	end

	always_comb begin
		seen = 3'd0;
		dir  = dmg_pkg::DIR_TOP;
		for (int k = 0; k < 4; k++) begin
			if (cand[k]) begin
				if (seen == pos) begin
					dir = 2'(k);
				end
				seen = seen + 3'd1;
			end
		end
	end

	assign res.carve = (n != 3'd0);
	assign res.dir   = dir;

endmodule

FILE: hw/rtl/dfs_maze_generator_step_top.sv
// ----------------------------------------------------------------------------
// dfs_maze_generator_step_top: depth-first backtracking maze carver
// Cell walls and visited marks live in one RAM, the cell stack in another.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (kind, cell_index, random_pick) enter on in_valid/in_stall,
//   result beats leave on out_valid/out_stall, one result per input beat.
//   A step reads the stack top, then the top cell and its four neighbours
//   one per cycle through the single cell RAM read port, then writes the
//   top cell back, and on a carving step the chosen neighbour as well.
//   A start finds the start column by a reciprocal multiplication in
//   ST_DIV. A step on an empty stack skips both RAMs and reports finished.
//   After reset the cell RAM is swept back to all walls and unvisited,
//   one cell per cycle over all GRID_SIDE*GRID_SIDE cells; in_stall is high
//   throughout. One item is in work at a time; the next beat is taken
//   while a finished result still waits in the output register. When the
//   receiver stalls, the result holds and the following result waits in
//   the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module dfs_maze_generator_step_top #(
	parameter int GRID_SIDE = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dmg_pkg::KIND_W-1:0]   kind,
	input  logic [dmg_pkg::CELL_W-1:0]   cell_index,
	input  logic [dmg_pkg::PICK_W-1:0]   random_pick,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [dmg_pkg::ACT_W-1:0]    action,
	output logic [dmg_pkg::CELL_W-1:0]   cell_res,
	output logic [dmg_pkg::CELL_W-1:0]   next_cell,
	output logic [dmg_pkg::WALL_W-1:0]   wall_bits,
	output logic                         cell_visited
);

	localparam int NCELLS = GRID_SIDE * GRID_SIDE;
	localparam int CW     = $clog2(NCELLS);
	localparam int RW     = $clog2(GRID_SIDE);
	localparam int SW     = $clog2(NCELLS + 1);
	localparam int IW     = dmg_pkg::CELL_W;
	localparam int XW     = ((CW > IW) ? CW : IW) + 1;
	localparam int EW     = CW + RW;
	localparam int CEW    = $bits(dmg_pkg::cell_ent_t);
	localparam int AW     = dmg_pkg::ACT_W;
	localparam int WW     = dmg_pkg::WALL_W;
	localparam int QSH    = IW + RW;
	localparam int QMUL   = ((1 << QSH) + GRID_SIDE - 1) / GRID_SIDE;
	localparam int QPW    = 2 * IW + 2;

	dmg_pkg::state_t state_q, state_d;

	logic                       c_we, c_re;
	logic [CW-1:0]              c_waddr, c_raddr;
	dmg_pkg::cell_ent_t         c_wdata, c_rdata;
	logic                       s_we, s_re;
	logic [CW-1:0]              s_waddr, s_raddr;
	logic [EW-1:0]              s_wdata, s_rdata;

	logic [SW-1:0]              count_q;
	logic                       fin_q;
	logic [CW-1:0]              clr_q;
	logic [2:0]                 idx_q;
	logic                       out_valid_q;

	logic [dmg_pkg::KIND_W-1:0] kind_q;
	logic [IW-1:0]              cell_q;
	logic [dmg_pkg::PICK_W-1:0] pick_in_q;
	logic [CW-1:0]              top_q;
	logic [RW-1:0]              col_q;
	logic [RW-1:0]              rem_q;
	dmg_pkg::cell_ent_t         top_ent_q;
	dmg_pkg::cell_ent_t         nb_ent_q [4];
	dmg_pkg::pick_res_t         pick_q;
	dmg_pkg::pick_res_t         pick_d;

	logic [AW-1:0]              res_act_q, action_q;
	logic [IW-1:0]              res_cell_q, cell_res_q;
	logic [IW-1:0]              res_next_q, next_cell_q;
	logic [WW-1:0]              res_walls_q, wall_bits_q;
	logic                       res_vis_q, cell_visited_q;

	logic                       accept;
	logic                       out_load;
	logic [SW-1:0]              cnt_m1;
	logic [XW-1:0]              in_x, cell_x;
	logic                       in_grid;
	logic                       start_ok;
	logic [CW:0]                top_x;
	logic [3:0]                 nb_ok;
	logic [3:0]                 cand;
	logic [CW-1:0]              nb_addr [4];
	logic [RW-1:0]              nb_col [4];
	logic [2:0]                 idx_m1;
	logic [QPW-1:0]             quo_prod;
	logic [IW-1:0]              quo;
	logic [IW-1:0]              col_start;
	logic [WW-1:0]              top_walls_new;
	dmg_pkg::cell_ent_t         nb_new;
	logic [1:0]                 dir_opp;

	dmg_ram #(.WIDTH(CEW), .DEPTH(NCELLS)) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	dmg_ram #(.WIDTH(EW), .DEPTH(NCELLS)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	dmg_pick u_pick (
		.cand        (cand),
		.random_pick (pick_in_q),
		.res         (pick_d)
	);

	assign accept    = in_valid && !in_stall;
	assign cnt_m1    = count_q - SW'(1);
	assign in_x      = XW'(cell_index);
	assign cell_x    = XW'(cell_q);
	assign in_grid   = (cell_x < XW'(NCELLS));
	assign start_ok  = (kind_q == dmg_pkg::KIND_START) && (count_q == '0) && !fin_q && in_grid;
	assign top_x     = {1'b0, top_q};
	assign idx_m1    = idx_q - 3'd1;
	assign quo_prod  = QPW'(cell_q) * QPW'(QMUL);
	assign quo       = IW'(quo_prod >> QSH);
	assign col_start = cell_q - quo * IW'(GRID_SIDE);
	assign dir_opp   = pick_q.dir + dmg_pkg::DIR_BOTTOM;

	always_comb begin
		nb_ok[dmg_pkg::DIR_TOP]    = (top_x >= (CW+1)'(GRID_SIDE));
		nb_ok[dmg_pkg::DIR_RIGHT]  = (col_q != RW'(GRID_SIDE - 1));
		nb_ok[dmg_pkg::DIR_BOTTOM] = (top_x < (CW+1)'(NCELLS - GRID_SIDE));
		nb_ok[dmg_pkg::DIR_LEFT]   = (col_q != '0);
		nb_addr[dmg_pkg::DIR_TOP]    = nb_ok[dmg_pkg::DIR_TOP] ?
			top_q - CW'(GRID_SIDE) : top_q;
		nb_addr[dmg_pkg::DIR_RIGHT]  = nb_ok[dmg_pkg::DIR_RIGHT] ? top_q + CW'(1) : top_q;
		nb_addr[dmg_pkg::DIR_BOTTOM] = nb_ok[dmg_pkg::DIR_BOTTOM] ?
			top_q + CW'(GRID_SIDE) : top_q;
		nb_addr[dmg_pkg::DIR_LEFT]   = nb_ok[dmg_pkg::DIR_LEFT] ? top_q - CW'(1) : top_q;
		nb_col[dmg_pkg::DIR_TOP]     = col_q;
		nb_col[dmg_pkg::DIR_RIGHT]   = col_q + RW'(1);
		nb_col[dmg_pkg::DIR_BOTTOM]  = col_q;
		nb_col[dmg_pkg::DIR_LEFT]    = col_q - RW'(1);
		for (int k = 0; k < 4; k++) begin
			cand[k] = nb_ok[k] && !nb_ent_q[k].vis;
		end
	end

	assign top_walls_new = top_ent_q.walls &
		~(pick_q.carve ? dmg_pkg::wall_mask(pick_q.dir) : '0);
	assign nb_new.vis    = nb_ent_q[pick_q.dir].vis;
	assign nb_new.walls  = nb_ent_q[pick_q.dir].walls & ~dmg_pkg::wall_mask(dir_opp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmg_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		out_load = 1'b0;
		c_we     = 1'b0;
		c_waddr  = top_q;
		c_wdata  = dmg_pkg::CELL_RESET;
		c_re     = 1'b0;
		c_raddr  = top_q;
		s_we     = 1'b0;
		s_waddr  = '0;
		s_wdata  = {cell_x[CW-1:0], rem_q};
		s_re     = 1'b0;
		s_raddr  = cnt_m1[CW-1:0];
		unique case (state_q)
			dmg_pkg::ST_CLEAR: begin
				c_we    = 1'b1;
				c_waddr = clr_q;
				if (clr_q == CW'(NCELLS - 1)) begin
					state_d = dmg_pkg::ST_IDLE;
				end
			end
			dmg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (kind == dmg_pkg::KIND_STEP) begin
						if (count_q == '0) begin
							state_d = dmg_pkg::ST_DONE;
						end else begin
							s_re    = 1'b1;
							state_d = dmg_pkg::ST_STACK;
						end
					end else begin
						c_re    = 1'b1;
						c_raddr = in_x[CW-1:0];
						state_d = (kind == dmg_pkg::KIND_START) ?
							dmg_pkg::ST_DIV : dmg_pkg::ST_REPORT;
					end
				end
			end
			dmg_pkg::ST_STACK: begin
				c_re    = 1'b1;
				c_raddr = s_rdata[EW-1:RW];
				state_d = dmg_pkg::ST_FETCH;
			end
			dmg_pkg::ST_FETCH: begin
				if (idx_q != dmg_pkg::NB_CNT) begin
					c_re    = 1'b1;
					c_raddr = nb_addr[idx_q[1:0]];
				end else begin
					state_d = dmg_pkg::ST_PICK;
				end
			end
			dmg_pkg::ST_PICK: begin
				state_d = dmg_pkg::ST_WR_TOP;
			end
			dmg_pkg::ST_WR_TOP: begin
				c_we    = 1'b1;
				c_waddr = top_q;
				c_wdata = '{vis: 1'b1, walls: top_walls_new};
				if (pick_q.carve) begin
					s_we    = (count_q < SW'(NCELLS));
					s_waddr = count_q[CW-1:0];
					s_wdata = {nb_addr[pick_q.dir], nb_col[pick_q.dir]};
					state_d = dmg_pkg::ST_WR_NB;
				end else begin
					state_d = dmg_pkg::ST_DONE;
				end
			end
			dmg_pkg::ST_WR_NB: begin
				c_we    = 1'b1;
				c_waddr = nb_addr[pick_q.dir];
				c_wdata = nb_new;
				state_d = dmg_pkg::ST_DONE;
			end
			dmg_pkg::ST_DIV: begin
				state_d = dmg_pkg::ST_REPORT;
			end
			dmg_pkg::ST_REPORT: begin
				s_we    = start_ok;
				state_d = dmg_pkg::ST_DONE;
			end
			dmg_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = dmg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dmg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			fin_q       <= 1'b0;
			clr_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == dmg_pkg::ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (accept && kind == dmg_pkg::KIND_STEP && count_q == '0) begin
				fin_q <= 1'b1;
			end
			if (state_q == dmg_pkg::ST_STACK) begin
				idx_q <= '0;
			end else if (state_q == dmg_pkg::ST_FETCH) begin
				idx_q <= idx_q + 3'd1;
			end
			if (state_q == dmg_pkg::ST_WR_TOP) begin
				if (pick_q.carve) begin
					if (count_q < SW'(NCELLS)) begin
						count_q <= count_q + SW'(1);
					end
				end else begin
					count_q <= cnt_m1;
				end
			end else if (state_q == dmg_pkg::ST_REPORT && start_ok) begin
				count_q <= SW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind;
			cell_q    <= cell_index;
			pick_in_q <= random_pick;
			if (kind == dmg_pkg::KIND_STEP && count_q == '0) begin
				res_act_q   <= dmg_pkg::ACT_FINISHED;
				res_cell_q  <= '0;
				res_next_q  <= '0;
				res_walls_q <= '0;
				res_vis_q   <= 1'b0;
			end
		end
		unique case (state_q)
			dmg_pkg::ST_STACK: begin
				top_q <= s_rdata[EW-1:RW];
				col_q <= s_rdata[RW-1:0];
			end
			dmg_pkg::ST_FETCH: begin
				if (idx_q == '0) begin
					top_ent_q <= c_rdata;
				end else begin
					nb_ent_q[idx_m1[1:0]] <= c_rdata;
				end
			end
			dmg_pkg::ST_PICK: begin
				pick_q <= pick_d;
			end
			dmg_pkg::ST_WR_TOP: begin
				res_act_q   <= pick_q.carve ? dmg_pkg::ACT_CARVED : dmg_pkg::ACT_BACKTRACK;
				res_cell_q  <= IW'(top_q);
				res_next_q  <= pick_q.carve ? IW'(nb_addr[pick_q.dir]) : '0;
				res_walls_q <= top_walls_new;
				res_vis_q   <= 1'b1;
			end
			dmg_pkg::ST_DIV: begin
				rem_q <= RW'(col_start);
			end
			dmg_pkg::ST_REPORT: begin
				if (kind_q == dmg_pkg::KIND_START) begin
					res_act_q <= start_ok ? dmg_pkg::ACT_START_OK : dmg_pkg::ACT_START_IGN;
				end else begin
					res_act_q <= dmg_pkg::ACT_READ;
				end
				res_cell_q  <= cell_q;
				res_next_q  <= '0;
				res_walls_q <= in_grid ? c_rdata.walls : '0;
				res_vis_q   <= in_grid ? c_rdata.vis : 1'b0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			action_q       <= res_act_q;
			cell_res_q     <= res_cell_q;
			next_cell_q    <= res_next_q;
			wall_bits_q    <= res_walls_q;
			cell_visited_q <= res_vis_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign cell_res     = cell_res_q;
	assign next_cell    = next_cell_q;
	assign wall_bits    = wall_bits_q;
	assign cell_visited = cell_visited_q;

endmodule
